FILE: sv/assert_macros.svh
// Assertion macros shared by the checker modules.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lepe_pkg.sv
// Shared types, codes and tables of the LED effect pattern engine.
// No dependencies.
package lepe_pkg;

  localparam int LED_COUNT = 4;
  localparam int LEDS_USED = (LED_COUNT > 4) ? 4 : LED_COUNT;
  localparam int LED_CNT_W = 3;

  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_SET     = 2'd1;
  localparam logic [1:0] ACT_REFRESH = 2'd2;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_SOLID  = 2'd1;
  localparam logic [1:0] MODE_BREATH = 2'd2;
  localparam logic [1:0] MODE_FLASH  = 2'd3;

  localparam logic [1:0] REG_BREATH_PERIOD = 2'd0;
  localparam logic [1:0] REG_FLASH_TIME    = 2'd1;

  localparam logic [15:0] FALLBACK_BREATH = 16'd3000;
  localparam logic [15:0] FALLBACK_FLASH  = 16'd500;

  localparam logic [5:0] DIV_LAST  = 6'd31;
  localparam logic [5:0] FRAC_LAST = 6'd39;

  typedef struct packed {
    logic start;
    logic with_frac;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

  localparam logic [7:0] QUARTER_UP [65] = '{
    8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149, 8'd152, 8'd155,
    8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd184,
    8'd187, 8'd190, 8'd193, 8'd195, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210,
    8'd213, 8'd215, 8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
    8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244, 8'd245, 8'd246,
    8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254,
    8'd254, 8'd254, 8'd254, 8'd254, 8'd255
  };

  function automatic logic [7:0] sine_level(input logic [7:0] k);
    logic [7:0] m;
    logic [6:0] a;
    m = 8'd0;
    if (k <= 8'd64) begin
      a = k[6:0];
    end else if (k < 8'd128) begin
      m = 8'd128 - k;
      a = m[6:0];
    end else begin
      m = k - 8'd128;
      if (m > 8'd64) m = 8'd128 - m;
      a = m[6:0];
    end
    if (k < 8'd128) return QUARTER_UP[a];
    if (a == 7'd64) return 8'd0;
    return 8'd254 - QUARTER_UP[a];
  endfunction

  function automatic logic [23:0] scale_color(input logic [23:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] bl;
    r  = c[23:16] * b;
    g  = c[15:8] * b;
    bl = c[7:0] * b;
    return {r[15:8], g[15:8], bl[15:8]};
  endfunction

endpackage

FILE: sv/led_effect_pattern_engine_core.sv
// Top level of the LED effect pattern engine: per-LED state, sequencer, output.
// Depends on lepe_pkg and lepe_div.
//
// Usage: drive in_* and pulse start while busy is low; the transaction is taken
// at that edge. A tick transaction advances the millisecond counter. A set
// transaction latches, then compares and stores.
// A refresh transaction reports LEDs 0..3 in order, one result per LED, each on
// out_* for exactly one cycle with out_valid high; out_last marks LED 3.
// Off and solid LEDs are reported from the stored state; flashing and breathing
// LEDs use the shared one-bit-per-cycle divider (32 remainder steps, plus 8
// fraction steps for the sine index).
// A full refresh keeps busy high from the accepting edge until the last result;
// busy drops in the cycle in which the last result is on out_*, so the next
// transaction can be taken in that cycle. Results cannot be held off by the receiver.
// cfg_we writes register cfg_index with cfg_data; index 0 is the default breathing
// period, index 1 the default flash time, others are dropped.
// Reset (rst_n low at a clock edge) returns all LEDs to off with default timing,
// clears the millisecond counter and restores the register defaults.
module led_effect_pattern_engine_core import lepe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [1:0]  in_led_index,
  input  logic [1:0]  in_mode,
  input  logic [23:0] in_color,
  input  logic [15:0] in_on_time,
  input  logic [15:0] in_off_time,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_pixel_index,
  output logic [23:0] out_pixel_color,
  output logic        out_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SET   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_SHADE = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] now_r;
  logic [15:0] dflt_breath_r;
  logic [15:0] dflt_flash_r;

  logic [1:0]  item_mode_r;
  logic [23:0] item_color_r;
  logic [15:0] item_on_r;
  logic [15:0] item_off_r;

  logic [1:0]  mode_r      [LEDS_USED];
  logic [23:0] color_r     [LEDS_USED];
  logic [15:0] req_on_r    [LEDS_USED];
  logic [15:0] req_off_r   [LEDS_USED];
  logic [15:0] breath_r    [LEDS_USED];
  logic [15:0] flash_on_r  [LEDS_USED];
  logic [15:0] flash_off_r [LEDS_USED];
  logic [31:0] flash_st_r  [LEDS_USED];

  logic [7:0]  level_r, level_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_index_r, out_index_nxt;
  logic [23:0] out_color_r, out_color_nxt;
  logic        out_last_r, out_last_nxt;

  logic        accept;
  logic        set_store;
  logic        is_last_led;
  logic [15:0] cur_breath;
  logic [15:0] cur_on;
  logic [15:0] cur_off;
  div_ctl_t    div_ctl;
  div_sts_t    div_sts;
  logic [31:0] div_dividend;
  logic [16:0] div_divisor;
  logic [16:0] div_rem;
  logic [7:0]  div_quo;

  assign busy        = state_r != S_IDLE;
  assign accept      = start && !busy;
  assign is_last_led = {1'b0, idx_r} == LED_CNT_W'(LEDS_USED - 1);

  assign cur_breath = (breath_r[idx_r] != 16'd0) ? breath_r[idx_r] : FALLBACK_BREATH;
  assign cur_on     = (flash_on_r[idx_r] != 16'd0) ? flash_on_r[idx_r] : FALLBACK_FLASH;
  assign cur_off    = (flash_off_r[idx_r] != 16'd0) ? flash_off_r[idx_r] : FALLBACK_FLASH;

  assign set_store = (state_r == S_SET) && ({1'b0, idx_r} < LED_CNT_W'(LEDS_USED)) &&
                     !(mode_r[idx_r] == item_mode_r && color_r[idx_r] == item_color_r &&
                       req_on_r[idx_r] == item_on_r && req_off_r[idx_r] == item_off_r);

  lepe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts_o    (div_sts),
    .rem      (div_rem),
    .quo      (div_quo)
  );

  always_comb begin
    state_nxt         = state_r;
    idx_nxt           = idx_r;
    level_nxt         = level_r;
    out_valid_nxt     = 1'b0;
    out_index_nxt     = out_index_r;
    out_color_nxt     = out_color_r;
    out_last_nxt      = out_last_r;
    div_ctl.start     = 1'b0;
    div_ctl.with_frac = 1'b0;
    div_dividend      = now_r;
    div_divisor       = {1'b0, cur_breath};
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_SET) begin
            idx_nxt   = in_led_index;
            state_nxt = S_SET;
          end else if (in_action == ACT_REFRESH) begin
            idx_nxt   = 2'd0;
            state_nxt = S_LOAD;
          end
        end
      end
      S_SET: begin
        state_nxt = S_IDLE;
      end
      S_LOAD: begin
        unique case (mode_r[idx_r])
          MODE_OFF, MODE_SOLID: begin
            out_valid_nxt = 1'b1;
            out_color_nxt = (mode_r[idx_r] == MODE_SOLID) ? color_r[idx_r] : 24'd0;
          end
          MODE_BREATH: begin
            div_ctl.start     = 1'b1;
            div_ctl.with_frac = 1'b1;
            state_nxt         = S_WAIT;
          end
          MODE_FLASH: begin
            div_ctl.start = 1'b1;
            div_dividend  = now_r - flash_st_r[idx_r];
            div_divisor   = {1'b0, cur_on} + {1'b0, cur_off};
            state_nxt     = S_WAIT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_WAIT: begin
        if (div_sts.done) begin
          if (mode_r[idx_r] == MODE_FLASH) begin
            out_valid_nxt = 1'b1;
            out_color_nxt = (div_rem < {1'b0, cur_on}) ? color_r[idx_r] : 24'd0;
          end else begin
            level_nxt = sine_level(div_quo);
            state_nxt = S_SHADE;
          end
        end
      end
      S_SHADE: begin
        out_valid_nxt = 1'b1;
        out_color_nxt = scale_color(color_r[idx_r], level_r);
      end
      default: state_nxt = S_IDLE;
    endcase
    if (out_valid_nxt) begin
      out_index_nxt = idx_r;
      out_last_nxt  = is_last_led;
      if (is_last_led) begin
        state_nxt = S_IDLE;
      end else begin
        idx_nxt   = idx_r + 2'd1;
        state_nxt = S_LOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      idx_r         <= 2'd0;
      now_r         <= 32'd0;
      dflt_breath_r <= FALLBACK_BREATH;
      dflt_flash_r  <= FALLBACK_FLASH;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < LEDS_USED; i++) begin
        mode_r[i]      <= MODE_OFF;
        color_r[i]     <= 24'd0;
        req_on_r[i]    <= 16'd0;
        req_off_r[i]   <= 16'd0;
        breath_r[i]    <= FALLBACK_BREATH;
        flash_on_r[i]  <= FALLBACK_FLASH;
        flash_off_r[i] <= FALLBACK_FLASH;
        flash_st_r[i]  <= 32'd0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept && in_action == ACT_TICK) now_r <= now_r + 32'd1;
      if (cfg_we && cfg_index == REG_BREATH_PERIOD) dflt_breath_r <= cfg_data;
      if (cfg_we && cfg_index == REG_FLASH_TIME) dflt_flash_r <= cfg_data;
      if (set_store) begin
        mode_r[idx_r]    <= item_mode_r;
        color_r[idx_r]   <= item_color_r;
        req_on_r[idx_r]  <= item_on_r;
        req_off_r[idx_r] <= item_off_r;
        if (item_mode_r == MODE_BREATH) begin
          breath_r[idx_r] <= (item_on_r != 16'd0) ? item_on_r : dflt_breath_r;
        end else if (item_mode_r == MODE_FLASH) begin
          flash_on_r[idx_r]  <= (item_on_r != 16'd0) ? item_on_r : dflt_flash_r;
          flash_off_r[idx_r] <= (item_off_r != 16'd0) ? item_off_r : dflt_flash_r;
          flash_st_r[idx_r]  <= now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    level_r     <= level_nxt;
    out_index_r <= out_index_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
    if (accept) begin
      item_mode_r  <= in_mode;
      item_color_r <= in_color;
      item_on_r    <= in_on_time;
      item_off_r   <= in_off_time;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_index_r;
  assign out_pixel_color = out_color_r;
  assign out_last        = out_last_r;

endmodule

FILE: sv/lepe_div.sv
// Shared restoring divider, one quotient bit per cycle: 32 integer steps for the
// remainder, optionally 8 more fraction steps. Depends on lepe_pkg.
module lepe_div import lepe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  div_ctl_t    ctl_i,
  input  logic [31:0] dividend,
  input  logic [16:0] divisor,
  output div_sts_t    sts_o,
  output logic [16:0] rem,
  output logic [7:0]  quo
);

  logic        run_r;
  logic        frac_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [31:0] dvd_r;
  logic [16:0] dvs_r;
  logic [16:0] rem_r;
  logic [7:0]  quo_r;

  logic [17:0] shifted;
  logic [17:0] diff;
  logic        ge;
  logic        last_step;

  assign shifted   = {rem_r, (cnt_r[5] == 1'b0) ? dvd_r[31] : 1'b0};
  assign ge        = shifted >= {1'b0, dvs_r};
  assign diff      = shifted - {1'b0, dvs_r};
  assign last_step = cnt_r == (frac_r ? FRAC_LAST : DIV_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= run_r && last_step;
      if (ctl_i.start) begin
        run_r <= 1'b1;
        cnt_r <= 6'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (last_step) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.start) begin
      frac_r <= ctl_i.with_frac;
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= 17'd0;
      quo_r  <= 8'd0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= ge ? diff[16:0] : shifted[16:0];
      quo_r <= {quo_r[6:0], ge};
    end
  end

  assign sts_o.done = done_r;
  assign rem        = rem_r;
  assign quo        = quo_r;

endmodule

FILE: sv/lepe_checker.sv
// Port-level checks of the LED effect pattern engine, bound to the top level.
// Depends on lepe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lepe_checker import lepe_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic [1:0]  out_pixel_index,
  input logic        out_last
);

  `ASSERT_IMPLY(a_mid_run_busy, out_valid && !out_last, busy, "result before last seen while idle")
  `ASSERT_NEXT(a_strobe_single, out_valid && out_last, !out_valid, "result strobe after last result")
  `ASSERT_NEXT(a_refresh_busy, start && !busy && in_action == ACT_REFRESH, busy, "refresh did not start")
  `ASSERT_NEXT(a_tick_quiet, start && !busy && in_action == ACT_TICK, !busy && !out_valid, "tick left idle")
  `ASSERT_IMPLY(a_last_index, out_valid && out_last, {1'b0, out_pixel_index} == LED_CNT_W'(LEDS_USED - 1), "last flag on wrong LED")

endmodule

bind led_effect_pattern_engine_core lepe_checker u_lepe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_pixel_index (out_pixel_index),
  .out_last        (out_last)
);
